// ===== hdl/ipfm_pkg.sv =====
// Package for the IPv4 subnet first-match filter.
// Holds command, status and register codes, the beat struct passed along the
// cell chain, and the prefix-to-mask function. Depends on nothing.
`default_nettype none

package ipfm_pkg;

  localparam int unsigned MAX_RULES_DEF = 64;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PLEN_W = 6;
  localparam int unsigned IDX_W = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HOST    = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_DFLT_PASS    = 2'd0,
    REG_FILTER_VALID = 2'd1,
    REG_KILL_MODE    = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [ADDR_W-1:0] ip;
    logic [ADDR_W-1:0] mask;
    logic              tst;
    logic              found;
    logic              drop;
    logic [IDX_W-1:0]  idx;
    status_t           status;
  } beat_t;

  function automatic logic [ADDR_W-1:0] mask_of_prefix(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] p;
    logic [PLEN_W-1:0] sh;
    logic [ADDR_W-1:0] m;
    p = (plen > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : plen;
    sh = PLEN_W'(ADDR_W) - p;
    m = (p == '0) ? '0 : ({ADDR_W{1'b1}} << sh);
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ipv4_subnet_first_match_filter.sv =====
// Top level of the IPv4 subnet first-match filter: entry logic, rule count,
// configuration registers and the ipfm_cell chain. Depends on ipfm_pkg and ipfm_cell.
//
// Each rule lives in its own cell, and every beat (clear, append, test or
// none) walks the row of MAX_RULES cells, one cell per cycle, and leaves it
// after the last of the MAX_RULES cell registers. The chain is a pipeline:
// one beat is accepted every cycle unless the result side stalls, and results
// leave in command order. When the result side stalls, the whole chain holds.
// Configuration writes must only be made while no beat is in the chain.
`default_nettype none

module ipv4_subnet_first_match_filter #(
  parameter int unsigned MAX_RULES = ipfm_pkg::MAX_RULES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_ip_value,
  input  wire logic [5:0]  in_prefix_len,
  input  wire logic        in_exclude,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_allow,
  output logic             out_matched,
  output logic [5:0]       out_rule_index,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);

  localparam int unsigned CW = $clog2(MAX_RULES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RULES);

  logic                dflt_pass_r, filter_valid_r, kill_mode_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic                adv;
  logic                acc;
  logic                full;
  ipfm_pkg::cmd_t      cmd;
  logic [31:0]         mask;
  ipfm_pkg::beat_t     beat_in;
  ipfm_pkg::beat_t     beat_w [0:MAX_RULES];
  logic [CW-1:0]       cnt_w  [0:MAX_RULES];
  ipfm_pkg::beat_t     last;

  assign adv      = !(beat_w[MAX_RULES].valid && out_stall);
  assign in_stall = !adv || !rst_n;
  assign acc      = in_valid && !in_stall;
  assign cmd      = ipfm_pkg::cmd_t'(in_cmd);
  assign full     = (count_r >= MAX_C);
  assign mask     = ipfm_pkg::mask_of_prefix(in_prefix_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_pass_r    <= 1'b0;
      filter_valid_r <= 1'b0;
      kill_mode_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (ipfm_pkg::reg_idx_t'(cfg_index))
        ipfm_pkg::REG_DFLT_PASS:    dflt_pass_r    <= cfg_data;
        ipfm_pkg::REG_FILTER_VALID: filter_valid_r <= cfg_data;
        ipfm_pkg::REG_KILL_MODE:    kill_mode_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    beat_in        = '0;
    beat_in.valid  = acc;
    beat_in.cmd    = cmd;
    beat_in.ip     = in_ip_value;
    beat_in.tst    = (cmd == ipfm_pkg::CMD_TEST) && filter_valid_r && !kill_mode_r;
    unique case (cmd)
      ipfm_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      ipfm_pkg::CMD_APPEND: begin
        beat_in.ip   = in_ip_value & mask;
        beat_in.mask = mask;
        beat_in.drop = in_exclude;
        if (full) begin
          beat_in.status = ipfm_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          if ((in_ip_value & mask) != in_ip_value) begin
            beat_in.status = ipfm_pkg::ST_HOST;
          end
        end
      end
      default: ;
    endcase
  end

  assign beat_w[0] = beat_in;
  assign cnt_w[0]  = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc) begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    ipfm_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .beat_i (beat_w[i]),
      .cnt_i  (cnt_w[i]),
      .beat_o (beat_w[i+1]),
      .cnt_o  (cnt_w[i+1])
    );
  end

  assign last           = beat_w[MAX_RULES];
  assign out_valid      = last.valid;
  assign out_allow      = last.tst && (last.found ? !last.drop : dflt_pass_r);
  assign out_matched    = last.tst && last.found;
  assign out_rule_index = (last.tst && last.found) ? last.idx : '0;
  assign out_status     = last.status;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("Rule count exceeds the table size.");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (cmd == ipfm_pkg::CMD_APPEND) && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("Accepted append did not advance the rule count.");

  a_status_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ipfm_pkg::ST_OK)) |-> (!out_allow && !out_matched))
    else $error("Append result carries a test verdict.");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (cmd == ipfm_pkg::CMD_CLEAR)) |=> (count_r == '0))
    else $error("Accepted clear did not empty the table.");

endmodule

`default_nettype wire

// ===== hdl/ipfm_cell.sv =====
// One rule cell of the filter chain: holds one rule and registers the beat
// passing through it. Depends on ipfm_pkg.
`default_nettype none

module ipfm_cell #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire ipfm_pkg::beat_t beat_i,
  input  wire logic [CW-1:0]  cnt_i,
  output ipfm_pkg::beat_t     beat_o,
  output logic [CW-1:0]       cnt_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [ipfm_pkg::IDX_W-1:0] IDX6 = ipfm_pkg::IDX_W'(IDX % 64);

  logic [ipfm_pkg::ADDR_W-1:0] net_r, net_nxt;
  logic [ipfm_pkg::ADDR_W-1:0] mask_r, mask_nxt;
  logic                        drop_r, drop_nxt;
  ipfm_pkg::beat_t             beat_r, beat_nxt;
  logic [CW-1:0]               cnt_r;
  logic                        wr;
  logic                        hit;

  assign wr = beat_i.valid && (beat_i.cmd == ipfm_pkg::CMD_APPEND) &&
              (beat_i.status != ipfm_pkg::ST_FULL) && (cnt_i == IDX_C);
  assign hit = beat_i.valid && beat_i.tst && !beat_i.found && (cnt_i > IDX_C) &&
               ((beat_i.ip & mask_r) == net_r);

  always_comb begin
    net_nxt  = net_r;
    mask_nxt = mask_r;
    drop_nxt = drop_r;
    if (wr) begin
      net_nxt  = beat_i.ip;
      mask_nxt = beat_i.mask;
      drop_nxt = beat_i.drop;
    end
    beat_nxt = beat_i;
    if (hit) begin
      beat_nxt.found = 1'b1;
      beat_nxt.idx   = IDX6;
      beat_nxt.drop  = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      net_r  <= net_nxt;
      mask_r <= mask_nxt;
      drop_r <= drop_nxt;
      cnt_r  <= cnt_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;
  assign cnt_o  = cnt_r;

endmodule

`default_nettype wire

// ===== sim/ipv4_subnet_first_match_filter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_subnet_first_match_filter: a scoreboard class
// predicts every result beat from the accepted input beats and the registers.
// Depends on ipfm_pkg and the filter RTL.

module ipv4_subnet_first_match_filter_tb;

  localparam int unsigned CHAIN_CYCLES = ipfm_pkg::MAX_RULES_DEF + 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT_NS = 8_000_000;
  localparam int unsigned DEEP_QUOTA = 340;
  localparam int unsigned SHALLOW_QUOTA = 120;
  localparam int unsigned AW = ipfm_pkg::ADDR_W;
  localparam int unsigned NR = ipfm_pkg::MAX_RULES_DEF;
  // Register settings per phase, as {pass by default, filter valid, kill mode}.
  localparam logic [2:0] PHASE_CFG [8] = '{3'b110, 3'b010, 3'b111, 3'b000,
                                           3'b110, 3'b011, 3'b100, 3'b010};

  typedef struct packed {
    logic                       allow;
    logic                       matched;
    logic [ipfm_pkg::IDX_W-1:0] rule_idx;
    ipfm_pkg::status_t          status;
  } verdict_t;

  class filter_scoreboard;
    logic [AW-1:0] net_tbl [NR];
    logic [AW-1:0] mask_tbl [NR];
    logic          drop_tbl [NR];
    int unsigned   rule_cnt = 0;
    logic          dflt_allow = 1'b0;
    logic          filt_valid = 1'b0;
    logic          kill = 1'b0;
    verdict_t      verdict_q[$];
    int            fail_cnt = 0;
    int            result_cnt = 0;

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_cnt++;
    endtask

    function void write_reg(ipfm_pkg::reg_idx_t r, logic v);
      unique case (r)
        ipfm_pkg::REG_DFLT_PASS: dflt_allow = v;
        ipfm_pkg::REG_FILTER_VALID: filt_valid = v;
        ipfm_pkg::REG_KILL_MODE: kill = v;
        default: ;
      endcase
    endfunction

    function void note_beat(ipfm_pkg::cmd_t c, logic [AW-1:0] ip,
                            logic [ipfm_pkg::PLEN_W-1:0] plen, logic excl);
      verdict_t v;
      logic [AW-1:0] m;
      v = '0;
      unique case (c)
        ipfm_pkg::CMD_CLEAR: rule_cnt = 0;
        ipfm_pkg::CMD_APPEND: begin
          if (rule_cnt >= NR) begin
            v.status = ipfm_pkg::ST_FULL;
          end else begin
            // A shift of the full width or more leaves zero, so long prefixes saturate.
            m = ~({AW{1'b1}} >> plen);
            if ((ip & m) != ip) v.status = ipfm_pkg::ST_HOST;
            net_tbl[rule_cnt] = ip & m;
            mask_tbl[rule_cnt] = m;
            drop_tbl[rule_cnt] = excl;
            rule_cnt++;
          end
        end
        ipfm_pkg::CMD_TEST: begin
          if (filt_valid && !kill) begin
            v.allow = dflt_allow;
            for (int i = 0; i < rule_cnt; i++) begin
              if (!v.matched && (ip & mask_tbl[i]) == net_tbl[i]) begin
                v.matched = 1'b1;
                v.rule_idx = ipfm_pkg::IDX_W'(i);
                v.allow = !drop_tbl[i];
              end
            end
          end
        end
        default: ;
      endcase
      verdict_q.push_back(v);
    endfunction

    task check_result(verdict_t got);
      verdict_t want;
      result_cnt++;
      if (verdict_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing expected", result_cnt));
      end else begin
        want = verdict_q.pop_front();
        if (got.allow !== want.allow)
          report($sformatf("result beat %0d allow %b, expected %b",
                           result_cnt, got.allow, want.allow));
        if (got.matched !== want.matched)
          report($sformatf("result beat %0d matched %b, expected %b",
                           result_cnt, got.matched, want.matched));
        if (got.rule_idx !== want.rule_idx)
          report($sformatf("result beat %0d rule_index %0d, expected %0d",
                           result_cnt, got.rule_idx, want.rule_idx));
        if (got.status !== want.status)
          report($sformatf("result beat %0d status %0d, expected %0d",
                           result_cnt, got.status, want.status));
      end
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_cmd = '0;
  logic [AW-1:0] in_ip_value = '0;
  logic [5:0]    in_prefix_len = '0;
  logic          in_exclude = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_allow;
  logic          out_matched;
  logic [5:0]    out_rule_index;
  logic [1:0]    out_status;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic          cfg_data = 1'b0;

  filter_scoreboard sb = new();
  bit hold_req = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;
  int items_sent = 0;

  ipv4_subnet_first_match_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_ip_value    (in_ip_value),
    .in_prefix_len  (in_prefix_len),
    .in_exclude     (in_exclude),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_allow      (out_allow),
    .out_matched    (out_matched),
    .out_rule_index (out_rule_index),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check_result(verdict_t'({out_allow, out_matched, out_rule_index, out_status}));
  end

  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= (left % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("status: fail");
    $finish;
  end

  task automatic send_beat(ipfm_pkg::cmd_t c, logic [AW-1:0] ip, logic [5:0] plen,
                           logic excl);
    int gap;
    if (burst_left == 0 && !steady) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= c;
    in_ip_value <= ip;
    in_prefix_len <= plen;
    in_exclude <= excl;
    do @(posedge clk); while (in_stall);
    sb.note_beat(c, ip, plen, excl);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_filter(logic da, logic fv, logic km);
    ipfm_pkg::reg_idx_t order [4];
    logic               vals [4];
    order = '{ipfm_pkg::REG_NONE, ipfm_pkg::REG_DFLT_PASS, ipfm_pkg::REG_FILTER_VALID,
              ipfm_pkg::REG_KILL_MODE};
    vals = '{1'($urandom), da, fv, km};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= order[k];
      cfg_data <= vals[k];
      @(posedge clk);
      sb.write_reg(order[k], vals[k]);
    end
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [5:0] random_prefix();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'($urandom_range(33, 63));
    if (r == 2) return 6'd32;
    return 6'($urandom_range(1, 31));
  endfunction

  task automatic noise_run();
    int n;
    n = $urandom_range(5, 20);
    repeat (n)
      send_beat(ipfm_pkg::cmd_t'($urandom_range(0, 3)), $urandom, 6'($urandom),
                1'($urandom));
  endtask

  // Usually clear, load a rule set with random content, then probe it mostly with
  // addresses that land inside one of the loaded subnets.
  task automatic rule_set_run(bit fill);
    int n_rules;
    int n_tests;
    int r;
    int k;
    logic [AW-1:0] ip;
    logic [5:0] plen;
    if ($urandom_range(0, 5) != 0)
      send_beat(ipfm_pkg::CMD_CLEAR, $urandom, 6'($urandom), 1'($urandom));
    n_rules = fill ? $urandom_range(62, 70) : $urandom_range(1, 12);
    repeat (n_rules) begin
      plen = random_prefix();
      ip = $urandom;
      if ($urandom_range(0, 1) == 0) ip = ip & ~({AW{1'b1}} >> plen);
      send_beat(ipfm_pkg::CMD_APPEND, ip, plen, ($urandom_range(0, 2) == 0));
    end
    n_tests = fill ? 40 : $urandom_range(4, 30);
    repeat (n_tests) begin
      r = $urandom_range(0, 9);
      if (r <= 6 && sb.rule_cnt > 0) begin
        k = $urandom_range(0, sb.rule_cnt - 1);
        ip = sb.net_tbl[k] | ($urandom & ~sb.mask_tbl[k]);
        if (r == 6) ip = ip ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        ip = $urandom;
      end
      if ($urandom_range(0, 24) == 0)
        send_beat(ipfm_pkg::CMD_NONE, $urandom, 6'($urandom), 1'($urandom));
      send_beat(ipfm_pkg::CMD_TEST, ip, 6'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int start;
    int quota;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_beat(ipfm_pkg::CMD_TEST, '1, '1, 1'b1);
    send_beat(ipfm_pkg::CMD_NONE, '0, '0, 1'b0);
    drain();
    set_filter(1'b1, 1'b1, 1'b0);
    send_beat(ipfm_pkg::CMD_CLEAR, '1, '1, 1'b1);
    send_beat(ipfm_pkg::CMD_TEST, 32'h0102_0304, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_APPEND, 32'hC0A8_0100, 6'd24, 1'b0);
    send_beat(ipfm_pkg::CMD_APPEND, 32'hC0A8_014D, 6'd24, 1'b1);
    send_beat(ipfm_pkg::CMD_APPEND, 32'h0A00_0000, 6'd40, 1'b0);
    send_beat(ipfm_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b1);
    send_beat(ipfm_pkg::CMD_APPEND, 32'hDEAD_BEEF, 6'd0, 1'b1);
    send_beat(ipfm_pkg::CMD_APPEND, 32'h0000_0000, 6'd63, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'hC0A8_0105, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'h0A00_0000, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'h0A00_0001, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'hFFFF_FFFF, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'h0000_0000, 6'd0, 1'b0);
    send_beat(ipfm_pkg::CMD_NONE, '1, '1, 1'b1);
    send_beat(ipfm_pkg::CMD_CLEAR, '0, '0, 1'b0);
    send_beat(ipfm_pkg::CMD_TEST, 32'h0000_0000, 6'd0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      drain();
      set_filter(PHASE_CFG[p][2], PHASE_CFG[p][1], PHASE_CFG[p][0]);
      start = items_sent;
      quota = (PHASE_CFG[p][1] && !PHASE_CFG[p][0]) ? DEEP_QUOTA : SHALLOW_QUOTA;
      if (p == 0) begin
        // The receiver holds off while a full table's worth of beats is offered.
        hold_req = 1'b1;
        steady = 1'b1;
        rule_set_run(1'b1);
        steady = 1'b0;
      end
      while (items_sent - start < quota) begin
        if ($urandom_range(0, 9) == 0) noise_run();
        else rule_set_run($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    repeat (CHAIN_CYCLES) @(posedge clk);
    if (sb.fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
